// ----- hw/rtl/sst_pkg.sv -----
// Shared types, codes and widths for the session slot table.
`default_nettype none

package sst_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int USER_W   = 16;
    localparam int CONN_W   = 10;
    localparam int ROLE_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_CONN  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_USER  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd3;
    localparam logic [OP_W-1:0] OP_INFO      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [USER_W-1:0] USER_FREE = '0;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [USER_W-1:0] user_id;
        logic [CONN_W-1:0] conn_id;
        logic [ROLE_W-1:0] role;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_active;
        logic [USER_W-1:0]   found_user;
        logic [ROLE_W-1:0]   found_role;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic              fill_pass;
        logic [OP_W-1:0]   opcode;
        logic [USER_W-1:0] user_id;
        logic [CONN_W-1:0] conn_id;
        logic [ROLE_W-1:0] role;
        logic              dup;
        logic              placed;
        logic              active;
        logic              found;
        logic [USER_W-1:0] found_user;
        logic [ROLE_W-1:0] found_role;
    } token_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sst_cell.sv -----
// One slot of the session table and the stage of the command chain that visits it.
`default_nettype none

module sst_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  sst_pkg::token_t    up,
    output sst_pkg::token_t    down
);

    logic [sst_pkg::USER_W-1:0] user_reg, user_next;
    logic [sst_pkg::CONN_W-1:0] conn_reg, conn_next;
    logic [sst_pkg::ROLE_W-1:0] role_reg, role_next;
    sst_pkg::token_t            down_reg, down_next;
    logic                       match_user;
    logic                       match_conn;

    assign match_user = (user_reg == up.user_id);
    assign match_conn = (conn_reg == up.conn_id);

    always_comb
    begin
        user_next = user_reg;
        conn_next = conn_reg;
        role_next = role_reg;
        down_next = up;
        if (up.valid)
        begin
            case (up.opcode)
                sst_pkg::OP_ADD:
                begin
                    if (!up.fill_pass)
                    begin
                        down_next.dup = up.dup | match_user;
                    end
                    else if (!up.placed && (user_reg == sst_pkg::USER_FREE))
                    begin
                        user_next        = up.user_id;
                        conn_next        = up.conn_id;
                        role_next        = up.role;
                        down_next.placed = 1'b1;
                    end
                end
                sst_pkg::OP_DEL_CONN:
                begin
                    if (match_conn)
                    begin
                        user_next = '0;
                        conn_next = '0;
                        role_next = '0;
                    end
                end
                sst_pkg::OP_DEL_USER:
                begin
                    if (match_user)
                    begin
                        user_next = '0;
                        conn_next = '0;
                        role_next = '0;
                    end
                end
                sst_pkg::OP_QUERY:
                begin
                    down_next.active = up.active | match_user;
                end
                sst_pkg::OP_INFO:
                begin
                    if (!up.found && match_conn && (user_reg != sst_pkg::USER_FREE))
                    begin
                        down_next.found      = 1'b1;
                        down_next.found_user = user_reg;
                        down_next.found_role = role_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_reg <= '0;
            conn_reg <= '0;
            role_reg <= '0;
            down_reg <= '0;
        end
        else
        begin
            user_reg <= user_next;
            conn_reg <= conn_next;
            role_reg <= role_next;
            down_reg <= down_next;
        end
    end

    assign down = down_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/session_slot_table.sv -----
// Top level of the session slot table: command chain control and response register.
`default_nettype none

// The table is a row of SLOTS cells, one slot each, and a command travels down the row one
// cell per cycle. Removes, queries, unused opcodes and duplicate adds need one trip; an add
// that finds no duplicate makes a duplicate check trip and then a fill trip. The response
// passes from the end of the row into a hold register and then into the output register.
// One command is in the row at a time, so the trip length through the row of cells sets the
// rate while the output is not stalled. A new request is taken as soon as the previous
// response has moved into the output register, even while that response still waits to be
// taken.
module session_slot_table #(
    parameter int SLOTS = sst_pkg::SLOTS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  sst_pkg::req_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output sst_pkg::rsp_t  rsp
);

    sst_pkg::token_t tok [SLOTS+1];
    sst_pkg::token_t exit_tok;
    sst_pkg::rsp_t   exit_rsp;
    logic            refill;
    logic            finish;
    logic            req_fire;
    logic            hold_move;

    logic            busy_reg, busy_next;
    logic            hold_valid_reg, hold_valid_next;
    sst_pkg::rsp_t   hold_reg, hold_next;
    logic            rsp_valid_reg, rsp_valid_next;
    sst_pkg::rsp_t   rsp_reg, rsp_next;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            sst_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .up    (tok[gi]),
                .down  (tok[gi+1])
            );
        end
    endgenerate

    assign exit_tok  = tok[SLOTS];
    assign req_ready = !busy_reg;
    assign req_fire  = req_valid && !busy_reg;
    assign refill    = exit_tok.valid && (exit_tok.opcode == sst_pkg::OP_ADD)
                       && !exit_tok.fill_pass && !exit_tok.dup;
    assign finish    = exit_tok.valid && !refill;
    assign hold_move = hold_valid_reg && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        tok[0] = '0;
        if (req_fire)
        begin
            tok[0].valid   = 1'b1;
            tok[0].opcode  = req.opcode;
            tok[0].user_id = req.user_id;
            tok[0].conn_id = req.conn_id;
            tok[0].role    = req.role;
        end
        else if (refill)
        begin
            tok[0]           = exit_tok;
            tok[0].fill_pass = 1'b1;
        end
    end

    always_comb
    begin
        exit_rsp            = '0;
        exit_rsp.status     = sst_pkg::ST_OK;
        exit_rsp.is_active  = exit_tok.active;
        exit_rsp.found_user = exit_tok.found_user;
        exit_rsp.found_role = exit_tok.found_role;
        case (exit_tok.opcode)
            sst_pkg::OP_ADD:
            begin
                if (exit_tok.dup)
                begin
                    exit_rsp.status = sst_pkg::ST_ALREADY;
                end
                else if (!exit_tok.placed)
                begin
                    exit_rsp.status = sst_pkg::ST_FULL;
                end
            end
            sst_pkg::OP_INFO:
            begin
                if (!exit_tok.found)
                begin
                    exit_rsp.status = sst_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy_next       = busy_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (hold_move)
        begin
            rsp_valid_next  = 1'b1;
            rsp_next        = hold_reg;
            hold_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
        if (finish)
        begin
            hold_valid_next = 1'b1;
            hold_next       = exit_rsp;
        end
        if (req_fire)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sst_checker.sv -----
// Port-level checks for the session slot table and their attachment to the top level.
`default_nettype none

module sst_checker (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input sst_pkg::rsp_t rsp
);

    logic req_beat;

    assign req_beat = req_valid && req_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Response beat changed or dropped while stalled.");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> !req_ready)
        else $error("Request taken while a command is still in the slot chain.");

    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> !$rose(rsp_valid))
        else $error("Response appeared before the command crossed the slot chain.");

    a_active_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_active |->
            (rsp.status == sst_pkg::ST_OK) && (rsp.found_user == '0)
            && (rsp.found_role == '0))
        else $error("Active answer mixed with other response fields.");

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == sst_pkg::ST_NOT_FOUND) |->
            (rsp.found_user == '0) && (rsp.found_role == '0) && !rsp.is_active)
        else $error("Not-found response carries slot data.");

endmodule

bind session_slot_table sst_checker u_sst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ----- tb/session_slot_table_tb.sv -----
// Self-checking testbench for the session slot table: directed, back-pressure and random traffic.
`timescale 1ns / 100ps

module session_slot_table_tb;

    localparam int SLOTS      = sst_pkg::SLOTS_DEFAULT;
    localparam int QUIET_MAX  = 2000;
    localparam int DRAIN_WAIT = 2 * SLOTS + 8;
    localparam int LONG_HOLD  = 300;

    localparam logic [sst_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [sst_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    sst_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    sst_pkg::rsp_t rsp;

    logic [sst_pkg::USER_W-1:0] tbl_user [SLOTS];
    logic [sst_pkg::CONN_W-1:0] tbl_conn [SLOTS];
    logic [sst_pkg::ROLE_W-1:0] tbl_role [SLOTS];

    sst_pkg::rsp_t pending_rsp[$];

    bit idle_on = 1'b1;
    int hold_request = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int req_count = 0;
    int rsp_count = 0;
    int full_count = 0;
    int dup_count = 0;
    int info_hit_count = 0;

    session_slot_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic sst_pkg::rsp_t session_table_step(input sst_pkg::req_t r);
        sst_pkg::rsp_t o;
        logic dup;
        logic hit;
        int idx;
        o = '0;
        o.status = sst_pkg::ST_OK;
        case (r.opcode)
            sst_pkg::OP_ADD:
            begin
                dup = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_user[i] == r.user_id)
                        dup = 1'b1;
                if (dup)
                    o.status = sst_pkg::ST_ALREADY;
                else
                begin
                    idx = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (idx < 0 && tbl_user[i] == sst_pkg::USER_FREE)
                            idx = i;
                    if (idx < 0)
                        o.status = sst_pkg::ST_FULL;
                    else
                    begin
                        tbl_user[idx] = r.user_id;
                        tbl_conn[idx] = r.conn_id;
                        tbl_role[idx] = r.role;
                    end
                end
            end
            sst_pkg::OP_DEL_CONN:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_conn[i] == r.conn_id)
                    begin
                        tbl_user[i] = '0;
                        tbl_conn[i] = '0;
                        tbl_role[i] = '0;
                    end
            end
            sst_pkg::OP_DEL_USER:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_user[i] == r.user_id)
                    begin
                        tbl_user[i] = '0;
                        tbl_conn[i] = '0;
                        tbl_role[i] = '0;
                    end
            end
            sst_pkg::OP_QUERY:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_user[i] == r.user_id)
                        o.is_active = 1'b1;
            end
            sst_pkg::OP_INFO:
            begin
                hit = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                    if (!hit && tbl_conn[i] == r.conn_id
                        && tbl_user[i] != sst_pkg::USER_FREE)
                    begin
                        hit = 1'b1;
                        o.found_user = tbl_user[i];
                        o.found_role = tbl_role[i];
                    end
                if (!hit)
                    o.status = sst_pkg::ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic sst_pkg::req_t make_req(input logic [sst_pkg::OP_W-1:0] op,
                                               input logic [sst_pkg::USER_W-1:0] user,
                                               input logic [sst_pkg::CONN_W-1:0] conn,
                                               input logic [sst_pkg::ROLE_W-1:0] role);
        sst_pkg::req_t r;
        r.opcode = op;
        r.user_id = user;
        r.conn_id = conn;
        r.role = role;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Users come mostly from a pool slightly larger than the table so that adds collide,
    // the table fills up and removes hit live sessions.
    function automatic sst_pkg::req_t rand_request();
        sst_pkg::req_t r;
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 38)
            r.opcode = sst_pkg::OP_ADD;
        else if (pick < 48)
            r.opcode = sst_pkg::OP_DEL_CONN;
        else if (pick < 60)
            r.opcode = sst_pkg::OP_DEL_USER;
        else if (pick < 74)
            r.opcode = sst_pkg::OP_QUERY;
        else if (pick < 92)
            r.opcode = sst_pkg::OP_INFO;
        else
            r.opcode = sst_pkg::OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        pick = $urandom_range(99, 0);
        if (pick < 6)
            r.user_id = sst_pkg::USER_FREE;
        else if (pick < 14)
            r.user_id = sst_pkg::USER_W'($urandom());
        else if (pick < 17)
            r.user_id = '1;
        else
            r.user_id = sst_pkg::USER_W'($urandom_range(SLOTS + 4, 1));
        pick = $urandom_range(99, 0);
        if (pick < 70)
            r.conn_id = sst_pkg::CONN_W'($urandom_range(7, 0));
        else if (pick < 88)
            r.conn_id = sst_pkg::CONN_W'($urandom());
        else
            r.conn_id = '1;
        r.role = sst_pkg::ROLE_W'($urandom());
        return r;
    endfunction

    task automatic send_req(input sst_pkg::req_t r, input int gap);
        sst_pkg::rsp_t want;
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req = r;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        want = session_table_step(r);
        pending_rsp.push_back(want);
        req_count++;
        if (r.opcode == sst_pkg::OP_ADD && want.status == sst_pkg::ST_FULL)
            full_count++;
        if (r.opcode == sst_pkg::OP_ADD && want.status == sst_pkg::ST_ALREADY)
            dup_count++;
        if (r.opcode == sst_pkg::OP_INFO && want.status == sst_pkg::ST_OK)
            info_hit_count++;
        @(negedge clk);
    endtask

    task automatic test_empty_table();
        send_req(make_req(sst_pkg::OP_INFO, sst_pkg::USER_FREE, '0, '0), 0);
        send_req(make_req(sst_pkg::OP_QUERY, sst_pkg::USER_FREE, '0, '0), 0);
        send_req(make_req(sst_pkg::OP_ADD, sst_pkg::USER_FREE, sst_pkg::CONN_W'(5),
                          sst_pkg::ROLE_W'(1)), 0);
        send_req(make_req(sst_pkg::OP_DEL_USER, sst_pkg::USER_FREE, '0, '0), 0);
        send_req(make_req(OP_SPARE_HI, '1, '1, '1), 0);
    endtask

    task automatic test_full_table();
        send_req(make_req(sst_pkg::OP_ADD, '1, '1, '1), 0);
        for (int i = 1; i < SLOTS; i++)
            send_req(make_req(sst_pkg::OP_ADD, sst_pkg::USER_W'(i), sst_pkg::CONN_W'(i),
                              sst_pkg::ROLE_W'(i)), pick_gap());
        send_req(make_req(sst_pkg::OP_ADD, sst_pkg::USER_W'(16'h8000), '0, '0), 0);
        send_req(make_req(sst_pkg::OP_ADD, sst_pkg::USER_FREE, '0, '0), 0);
        send_req(make_req(sst_pkg::OP_QUERY, sst_pkg::USER_FREE, '0, '0), 0);
        send_req(make_req(sst_pkg::OP_ADD, '1, sst_pkg::CONN_W'(3), sst_pkg::ROLE_W'(2)), 0);
        send_req(make_req(sst_pkg::OP_INFO, sst_pkg::USER_FREE, '1, '0), 0);
        send_req(make_req(sst_pkg::OP_DEL_CONN, sst_pkg::USER_FREE, '1, '0), 0);
        send_req(make_req(sst_pkg::OP_DEL_USER, sst_pkg::USER_W'(1), '0, '0), 0);
        send_req(make_req(sst_pkg::OP_INFO, sst_pkg::USER_FREE, sst_pkg::CONN_W'(1), '0), 0);
    endtask

    task automatic test_back_to_back(input int n);
        idle_on = 1'b0;
        repeat (n) send_req(rand_request(), 0);
        idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_request = LONG_HOLD;
        repeat (8) send_req(rand_request(), 0);
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) send_req(rand_request(), pick_gap());
    endtask

    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                rsp_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        sst_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_count++;
            if (pending_rsp.size() == 0)
            begin
                $error("response beat with no request outstanding: %h", rsp);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.is_active !== want.is_active)
                begin
                    $error("is_active: expected %0d, got %0d", want.is_active, rsp.is_active);
                    fail_count++;
                end
                if (rsp.found_user !== want.found_user)
                begin
                    $error("found_user: expected %0d, got %0d", want.found_user, rsp.found_user);
                    fail_count++;
                end
                if (rsp.found_role !== want.found_role)
                begin
                    $error("found_role: expected %0d, got %0d", want.found_role, rsp.found_role);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("FAIL session_slot_table");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_user[i] = '0;
            tbl_conn[i] = '0;
            tbl_role[i] = '0;
        end
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_full_table();
        test_back_to_back(60);
        test_output_backpressure();
        test_random_traffic(450);

        req_valid = 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d requests and %0d responses: %0d table-full adds, %0d duplicate adds,",
                 req_count, rsp_count, full_count, dup_count);
        $display("%0d info hits, one long response stall; %0d mismatches.",
                 info_hit_count, fail_count);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("PASS session_slot_table");
        else
            $display("FAIL session_slot_table");
        $finish;
    end

endmodule
